FILE: src/comr_pkg.sv
// Package: shared types, constants and codes for center-of-mass removal
package comr_pkg;
  localparam int MAX_PARTICLES_DEF = 1024;
  localparam int COORD_BITS_DEF    = 32;
  localparam int NCOORD            = 6;
  localparam int IDX_W             = 10;
  localparam int MASS_W            = 16;
  localparam int TMASS_W           = 32;
  localparam int SUM_W             = 64;
  localparam int OUT_W             = 32;
  localparam int CFG_IDX_W         = 1;
  localparam logic [MASS_W-1:0] MASS_RESET = 16'd256;

  localparam logic [CFG_IDX_W-1:0] REG_MASS_ZERO = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MASS_ONE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_LOADED = 2'd1,
    ST_NO_MEANS   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_OUT
  } state_t;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_READ = 1'b1
  } mode_t;

  typedef struct packed {
    logic load;       // accept a load beat
    logic read;       // issue memory read for a read beat
    logic div_start;  // start divider for coordinate div_k
    logic [2:0] div_k;
    logic set_valid;
    logic out_load;   // capture result
  } comr_cmd_t;

  typedef struct packed {
    logic div_done;
    logic means_valid;
  } comr_sts_t;
endpackage

FILE: src/comr_if.sv
// Interfaces: input, result and configuration channels
interface comr_in_if;
  import comr_pkg::*;
  logic valid;
  logic ready;
  logic mode;
  logic species;
  logic [IDX_W-1:0] index;
  logic signed [COORD_BITS_DEF-1:0] vel_x, vel_y, vel_z, pos_x, pos_y, pos_z;
  logic last;
  modport source(output valid, mode, species, index, vel_x, vel_y, vel_z,
                 pos_x, pos_y, pos_z, last, input ready);
  modport sink(input valid, mode, species, index, vel_x, vel_y, vel_z,
               pos_x, pos_y, pos_z, last, output ready);
endinterface

interface comr_out_if;
  import comr_pkg::*;
  logic valid;
  logic ready;
  logic out_species;
  logic signed [OUT_W-1:0] out_vel_x, out_vel_y, out_vel_z;
  logic signed [OUT_W-1:0] out_pos_x, out_pos_y, out_pos_z;
  logic [1:0] status;
  modport source(output valid, out_species, out_vel_x, out_vel_y, out_vel_z,
                 out_pos_x, out_pos_y, out_pos_z, status, input ready);
  modport sink(input valid, out_species, out_vel_x, out_vel_y, out_vel_z,
               out_pos_x, out_pos_y, out_pos_z, status, output ready);
endinterface

interface comr_cfg_if;
  import comr_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [MASS_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: src/comr_div.sv
// Divider: signed sum over unsigned mass, restoring, one quotient bit per cycle
module comr_div
  import comr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [SUM_W-1:0]      sum,
  input  logic [TMASS_W-1:0]    mass,
  output logic                  done,
  output logic [COORD_BITS-1:0] quot
);
  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]   q_r, q_nxt;
  logic [TMASS_W:0]   rem_r, rem_nxt;
  logic [TMASS_W-1:0] d_r, d_nxt;
  logic               neg_r, neg_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [TMASS_W:0]   trial;
  logic [SUM_W-1:0]   qs;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[TMASS_W-1:0], q_r[SUM_W-1]};
    if (start) begin
      neg_nxt  = sum[SUM_W-1];
      q_nxt    = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
      rem_nxt  = '0;
      d_nxt    = mass;
      cnt_nxt  = CNT_W'(SUM_W);
      busy_nxt = (mass != '0);
      done_nxt = (mass == '0);
      if (mass == '0) begin
        q_nxt   = '0;
        neg_nxt = 1'b0;
      end
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt   = {q_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    neg_r <= neg_nxt;
  end

  assign qs   = neg_r ? (~q_r + 1'b1) : q_r;
  assign quot = qs[COORD_BITS-1:0];
  assign done = done_r;
endmodule

FILE: src/comr_datapath.sv
// Datapath: particle memory, weighted sums, means and result register
module comr_datapath
  import comr_pkg::*;
#(
  parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  comr_cmd_t        cmd,
  output comr_sts_t        sts,
  comr_in_if.sink          in_ch,
  comr_out_if.source       out_ch,
  comr_cfg_if.sink         cfg_ch
);
  localparam int AW    = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
  localparam int ROW_W = 1 + NCOORD * COORD_BITS;

  logic [ROW_W-1:0] mem [MAX_PARTICLES];
  logic [ROW_W-1:0] rd_r;

  logic [MASS_W-1:0]  m0_r, m1_r;
  logic [SUM_W-1:0]   sum_r [NCOORD];
  logic [SUM_W-1:0]   sum_nxt [NCOORD];
  logic [TMASS_W-1:0] tmass_r, tmass_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [COORD_BITS-1:0] mean_r [NCOORD];
  logic               valid_r, valid_nxt;
  logic               err_nl_r, err_nv_r;

  logic [COORD_BITS-1:0] cin [NCOORD];
  logic [MASS_W-1:0]     mass;
  logic                  full;
  logic                  store;
  logic [ROW_W-1:0]      row;
  logic                  div_done;
  logic [COORD_BITS-1:0] quot;
  logic [SUM_W-1:0]      div_sum;
  logic [AW-1:0]         rd_addr;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m0_r <= MASS_RESET;
      m1_r <= MASS_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_MASS_ZERO: m0_r <= cfg_ch.data;
        REG_MASS_ONE:  m1_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign cin[0] = COORD_BITS'(in_ch.vel_x);
  assign cin[1] = COORD_BITS'(in_ch.vel_y);
  assign cin[2] = COORD_BITS'(in_ch.vel_z);
  assign cin[3] = COORD_BITS'(in_ch.pos_x);
  assign cin[4] = COORD_BITS'(in_ch.pos_y);
  assign cin[5] = COORD_BITS'(in_ch.pos_z);

  assign mass    = in_ch.species ? m1_r : m0_r;
  assign full    = valid_r ? 1'b0 : (cnt_r >= CNT_W'(MAX_PARTICLES));
  assign store   = cmd.load && !full;
  assign rd_addr = AW'(in_ch.index);

  always_comb begin
    row = {in_ch.species, cin[0], cin[1], cin[2], cin[3], cin[4], cin[5]};
    tmass_nxt = valid_r && cmd.load ? '0 : tmass_r;
    cnt_nxt   = valid_r && cmd.load ? '0 : cnt_r;
    valid_nxt = valid_r && !cmd.load;
    for (int k = 0; k < NCOORD; k++) begin
      sum_nxt[k] = valid_r && cmd.load ? '0 : sum_r[k];
      if (store) begin
        sum_nxt[k] = sum_nxt[k] + SUM_W'($signed({1'b0, mass}) * $signed(cin[k]));
      end
    end
    if (store) begin
      tmass_nxt = tmass_nxt + TMASS_W'(mass);
      cnt_nxt   = cnt_nxt + 1'b1;
    end
    if (cmd.set_valid) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmass_r <= '0;
      cnt_r   <= '0;
      valid_r <= 1'b0;
      for (int k = 0; k < NCOORD; k++) begin
        sum_r[k]  <= '0;
        mean_r[k] <= '0;
      end
    end else begin
      tmass_r <= tmass_nxt;
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
      for (int k = 0; k < NCOORD; k++) begin
        sum_r[k] <= sum_nxt[k];
      end
      if (div_done) begin
        mean_r[cmd.div_k] <= quot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      mem[cnt_nxt[AW-1:0] - 1'b1] <= row;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_r     <= mem[rd_addr];
      err_nv_r <= !valid_r;
      err_nl_r <= (CNT_W'(in_ch.index) >= cnt_r) || (32'(in_ch.index) >= MAX_PARTICLES);
    end
  end

  assign div_sum = sum_r[cmd.div_k];

  comr_div #(.COORD_BITS(COORD_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .sum   (div_sum),
    .mass  (tmass_r),
    .done  (div_done),
    .quot  (quot)
  );

  logic [COORD_BITS-1:0] diff [NCOORD];
  always_comb begin
    for (int k = 0; k < NCOORD; k++) begin
      diff[k] = rd_r[(NCOORD-1-k)*COORD_BITS +: COORD_BITS] - mean_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_ch.valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
    if (cmd.out_load) begin
      if (err_nv_r || err_nl_r) begin
        out_ch.status      <= err_nv_r ? ST_NO_MEANS : ST_NOT_LOADED;
        out_ch.out_species <= 1'b0;
        out_ch.out_vel_x   <= '0;
        out_ch.out_vel_y   <= '0;
        out_ch.out_vel_z   <= '0;
        out_ch.out_pos_x   <= '0;
        out_ch.out_pos_y   <= '0;
        out_ch.out_pos_z   <= '0;
      end else begin
        out_ch.status      <= ST_OK;
        out_ch.out_species <= rd_r[ROW_W-1];
        out_ch.out_vel_x   <= OUT_W'(diff[0]);
        out_ch.out_vel_y   <= OUT_W'(diff[1]);
        out_ch.out_vel_z   <= OUT_W'(diff[2]);
        out_ch.out_pos_x   <= OUT_W'(diff[3]);
        out_ch.out_pos_y   <= OUT_W'(diff[4]);
        out_ch.out_pos_z   <= OUT_W'(diff[5]);
      end
    end
  end

  assign sts.div_done    = div_done;
  assign sts.means_valid = valid_r;
endmodule

FILE: src/comr_ctrl.sv
// Controller: sequences loads, divisions and reads
module comr_ctrl
  import comr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_mode,
  input  logic      in_last,
  output logic      in_ready,
  input  logic      out_valid,
  input  logic      out_ready,
  input  comr_sts_t sts,
  output comr_cmd_t cmd
);
  state_t     state_r, state_nxt;
  logic [2:0] k_r, k_nxt;
  logic       acc;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    case (state_r)
      S_IDLE: begin
        if (acc && in_mode == MODE_READ) begin
          state_nxt = S_READ;
        end else if (acc && in_last) begin
          state_nxt = S_DIV;
          k_nxt     = '0;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          if (k_r == 3'(NCOORD - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      S_READ: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  logic start_r, start_nxt;
  always_comb begin
    cmd           = '0;
    cmd.div_k     = k_r;
    cmd.div_start = start_r;
    start_nxt     = 1'b0;
    case (state_r)
      S_IDLE: begin
        cmd.load  = acc && in_mode == MODE_LOAD;
        cmd.read  = acc && in_mode == MODE_READ;
        start_nxt = acc && in_mode == MODE_LOAD && in_last;
      end
      S_DIV: begin
        start_nxt = sts.div_done && k_r != 3'(NCOORD - 1);
        cmd.set_valid = sts.div_done && k_r == 3'(NCOORD - 1);
      end
      S_OUT: cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      start_r <= start_nxt;
    end
  end
endmodule

FILE: src/center_of_mass_removal.sv
// Top level: center-of-mass and net-momentum removal
//  channel | dir | handshake      | beat
//  in_     | in  | valid/ready    | mode, species, index, vel, pos, last
//  out_    | out | valid/ready    | species, corrected vel, pos, status
//  cfg_    | in  | valid/ready    | register index, mass data
// A load beat is stored on acceptance; a read passes through the particle memory
// read port and the result register. The last load runs six 64-step
// divisions in one shared divider. Reset is synchronous; a stalled result
// holds the next read.
module center_of_mass_removal
  import comr_pkg::*;
#(
  parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
  parameter int COORD_BITS    = COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  comr_in_if.sink    in_ch,
  comr_out_if.source out_ch,
  comr_cfg_if.sink   cfg_ch
);
  comr_cmd_t cmd;
  comr_sts_t sts;

  comr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_last   (in_ch.last),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  comr_datapath #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .COORD_BITS    (COORD_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sts    (sts),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );
endmodule

FILE: src/comr_checker.sv
// Checker: port-level properties, bound to the top level
module comr_checker
  import comr_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_mode,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] status
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status != 2'd3) else $error("bad status");
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode |-> ##2 !in_ready) else $error("read ended early");
  a_no_take_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode |=> !in_ready) else $error("took beat during read");
endmodule

bind center_of_mass_removal comr_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_mode   (in_ch.mode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .status    (out_ch.status)
);

FILE: test/center_of_mass_removal_tb.sv
// Testbench: center-of-mass and net-momentum removal, checked against a built-in predictor
module center_of_mass_removal_tb;
  import comr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic species;
    logic signed [31:0] vx, vy, vz, px, py, pz;
    status_t status;
  } particle_result_t;

  logic clk;
  logic rst_n;
  comr_in_if  in_ch();
  comr_out_if out_ch();
  comr_cfg_if cfg_ch();

  center_of_mass_removal dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [15:0] mass_zero, mass_one;
  logic store_species [MAX_PARTICLES_DEF];
  logic [31:0] store_coord [NCOORD][MAX_PARTICLES_DEF];
  logic [63:0] mass_sums [NCOORD];
  logic [31:0] total_mass;
  int unsigned loaded;
  logic [31:0] means [NCOORD];
  bit means_ok;

  particle_result_t expected_results[$];
  int mismatches;
  bit rx_hold;
  int rx_gap_max;
  int tx_gap_max;

  function automatic logic [31:0] quotient_toward_zero(logic [63:0] s, logic [31:0] m);
    logic [63:0] mag, q;
    if (m == 0) return 32'd0;
    mag = s[63] ? -s : s;
    q = mag / {32'd0, m};
    q = s[63] ? -q : q;
    return q[31:0];
  endfunction

  task automatic predict_beat(input logic mode, input logic sp, input logic [9:0] idx,
                              input logic [31:0] c [NCOORD], input logic lst);
    logic [15:0] m;
    logic signed [63:0] prod;
    particle_result_t r;
    if (mode == MODE_LOAD) begin
      if (means_ok) begin
        foreach (mass_sums[k]) mass_sums[k] = '0;
        total_mass = 0; loaded = 0; means_ok = 0;
      end
      if (loaded < MAX_PARTICLES_DEF) begin
        m = sp ? mass_one : mass_zero;
        store_species[loaded] = sp;
        for (int k = 0; k < NCOORD; k++) begin
          prod = $signed({48'd0, m}) * $signed({{32{c[k][31]}}, c[k]});
          store_coord[k][loaded] = c[k];
          mass_sums[k] += prod;
        end
        total_mass += m;
        loaded++;
      end
      if (lst) begin
        for (int k = 0; k < NCOORD; k++) means[k] = quotient_toward_zero(mass_sums[k], total_mass);
        means_ok = 1;
      end
    end else begin
      r = '0;
      if (!means_ok) r.status = ST_NO_MEANS;
      else if (idx >= loaded) r.status = ST_NOT_LOADED;
      else begin
        r.status = ST_OK;
        r.species = store_species[idx];
        r.vx = store_coord[0][idx] - means[0];
        r.vy = store_coord[1][idx] - means[1];
        r.vz = store_coord[2][idx] - means[2];
        r.px = store_coord[3][idx] - means[3];
        r.py = store_coord[4][idx] - means[4];
        r.pz = store_coord[5][idx] - means[5];
      end
      expected_results.push_back(r);
    end
  endtask

  function automatic int pick_gap(int maxg);
    int p;
    p = $urandom_range(0, 99);
    if (maxg == 0 || p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(4, maxg);
  endfunction

  task automatic send_beat(input logic mode, input logic sp, input logic [9:0] idx,
                           input logic [31:0] c [NCOORD], input logic lst);
    int g;
    g = pick_gap(tx_gap_max);
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode; in_ch.species <= sp; in_ch.index <= idx; in_ch.last <= lst;
    in_ch.vel_x <= c[0]; in_ch.vel_y <= c[1]; in_ch.vel_z <= c[2];
    in_ch.pos_x <= c[3]; in_ch.pos_y <= c[4]; in_ch.pos_z <= c[5];
    do @(posedge clk); while (!in_ch.ready);
    predict_beat(mode, sp, idx, c, lst);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'hffffffff : 32'd0;
      3: return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
      default: return $urandom;
    endcase
  endfunction

  task automatic load_one(input logic sp, input logic lst);
    logic [31:0] c [NCOORD];
    foreach (c[k]) c[k] = rand_coord();
    send_beat(MODE_LOAD, sp, 10'($urandom), c, lst);
  endtask

  task automatic read_one(input logic [9:0] idx);
    logic [31:0] c [NCOORD];
    foreach (c[k]) c[k] = $urandom;
    send_beat(MODE_READ, 1'($urandom), idx, c, 1'($urandom));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (500) @(negedge clk);
  endtask

  task automatic write_mass(input logic [CFG_IDX_W-1:0] r, input logic [15:0] v);
    @(negedge clk);
    cfg_ch.valid <= 1'b1; cfg_ch.index <= r; cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    if (r == REG_MASS_ZERO) mass_zero = v; else mass_one = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_set(input int n, input int nreads);
    for (int i = 0; i < n; i++) load_one(1'($urandom), i == n - 1);
    for (int i = 0; i < nreads; i++)
      read_one(10'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, n)));
  endtask

  task automatic test_directed();
    logic [31:0] c [NCOORD];
    read_one(10'd0);
    foreach (c[k]) c[k] = 32'h7fffffff;
    send_beat(MODE_LOAD, 1'b0, 10'd0, c, 1'b0);
    foreach (c[k]) c[k] = 32'h80000000;
    send_beat(MODE_LOAD, 1'b1, 10'h3ff, c, 1'b0);
    read_one(10'd0);
    foreach (c[k]) c[k] = 32'hffffffff;
    send_beat(MODE_LOAD, 1'b1, 10'd0, c, 1'b1);
    read_one(10'd0); read_one(10'd1); read_one(10'd2); read_one(10'd3); read_one(10'h3ff);
    drain();
    write_mass(REG_MASS_ZERO, 16'd0);
    write_mass(REG_MASS_ONE, 16'd0);
    run_set(3, 4);
    drain();
    write_mass(REG_MASS_ZERO, 16'hffff);
    write_mass(REG_MASS_ONE, 16'hffff);
    run_set(4, 5);
    drain();
  endtask

  task automatic test_full_store();
    write_mass(REG_MASS_ZERO, 16'd256);
    write_mass(REG_MASS_ONE, 16'd1);
    for (int i = 0; i < MAX_PARTICLES_DEF + 2; i++)
      load_one(1'($urandom), i == MAX_PARTICLES_DEF + 1);
    read_one(10'd0); read_one(10'h3ff);
    drain();
  endtask

  task automatic test_random();
    int left;
    left = 500;
    tx_gap_max = 20; rx_gap_max = 20;
    while (left > 0) begin
      int n;
      n = $urandom_range(1, 12);
      if ($urandom_range(0, 3) == 0) begin
        write_mass(CFG_IDX_W'($urandom_range(0, 1)),
                   16'($urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 1024)));
      end
      run_set(n, $urandom_range(4, 20));
      if ($urandom_range(0, 9) == 0) load_one(1'($urandom), 1'b0);
      left -= n + 10;
      drain();
    end
  endtask

  task automatic test_backpressure();
    run_set(6, 0);
    drain();
    rx_hold = 1;
    fork
      begin
        repeat (300) @(negedge clk);
        rx_hold = 0;
      end
      for (int i = 0; i < 40; i++) read_one(10'($urandom_range(0, 6)));
    join
    drain();
  endtask

  always @(posedge clk) begin
    particle_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
      end else begin
        e = expected_results.pop_front();
        if (out_ch.out_species !== e.species || out_ch.out_vel_x !== e.vx ||
            out_ch.out_vel_y !== e.vy || out_ch.out_vel_z !== e.vz ||
            out_ch.out_pos_x !== e.px || out_ch.out_pos_y !== e.py ||
            out_ch.out_pos_z !== e.pz || out_ch.status !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp sp=%0d v=%h %h %h p=%h %h %h st=%0d, got sp=%0d v=%h %h %h p=%h %h %h st=%0d",
                     e.species, e.vx, e.vy, e.vz, e.px, e.py, e.pz, e.status,
                     out_ch.out_species, out_ch.out_vel_x, out_ch.out_vel_y, out_ch.out_vel_z,
                     out_ch.out_pos_x, out_ch.out_pos_y, out_ch.out_pos_z, out_ch.status);
        end
      end
    end
  end

  int rx_wait;
  always @(negedge clk) begin
    if (rx_hold) out_ch.ready <= 1'b0;
    else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_ch.ready <= 1'b0;
    end else begin
      rx_wait <= pick_gap(rx_gap_max);
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    clk = 1'b0; rst_n = 1'b0;
    mismatches = 0; rx_hold = 0; rx_wait = 0;
    rx_gap_max = 0; tx_gap_max = 0;
    in_ch.valid = 0; in_ch.mode = 0; in_ch.species = 0; in_ch.index = 0; in_ch.last = 0;
    in_ch.vel_x = 0; in_ch.vel_y = 0; in_ch.vel_z = 0;
    in_ch.pos_x = 0; in_ch.pos_y = 0; in_ch.pos_z = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0; cfg_ch.index = REG_MASS_ZERO; cfg_ch.data = 0;
    mass_zero = MASS_RESET; mass_one = MASS_RESET;
    foreach (mass_sums[k]) begin
      mass_sums[k] = '0; means[k] = '0;
    end
    total_mass = 0; loaded = 0; means_ok = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_store();
    test_backpressure();
    test_random();
    drain();
    if (mismatches == 0 && expected_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
